>>> rtl/core/dqle_pkg.sv
package dqle_pkg;

  localparam int LABEL_DEPTH_DEF = 32;
  localparam logic [7:0] DOT_CHAR = 8'd46;

  typedef struct packed {
    logic [7:0] name_char;
    logic       end_of_name;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       label_overflow;
  } out_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       store;
    logic       flush;
    logic       last;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEN,
    BK_DATA,
    BK_TERM
  } back_state_t;

endpackage

>>> rtl/core/dns_qname_label_encoder_core.sv
// Channel   Direction  Handshake                 Word
// char      in         char_valid / char_stall   in_word_t  (name_char, end_of_name)
// byte      out        byte_valid / byte_stall   out_word_t (out_byte, last_byte,
//                                                            label_overflow)
//
// A character that does not close a label is stored in the back end's memory.
// A closing dot or final character then sends the length N of the label, its N
// bytes and, after a final char, the terminator; one word per cycle unless stalled.
// Reset clears the queue, label count, overflow flag and output valid.
// A stalled output holds its word; the two-entry queue accepts until it is full.
module dns_qname_label_encoder_core
  import dqle_pkg::*;
#(
  parameter int LABEL_DEPTH = LABEL_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  in_word_t  char_word,
  output logic      byte_valid,
  input  logic      byte_stall,
  output out_word_t byte_word
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  dqle_front u_front (
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  dqle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  dqle_back #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word)
  );

endmodule

>>> rtl/core/dqle_queue.sv
module dqle_queue
  import dqle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/dqle_front.sv
module dqle_front
  import dqle_pkg::*;
(
  input  logic     char_valid,
  output logic     char_stall,
  input  in_word_t char_word,
  input  logic     q_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic is_dot;

  assign is_dot     = (char_word.name_char == DOT_CHAR);
  assign char_stall = q_full;
  assign push       = char_valid && !q_full;

  always_comb begin
    push_cmd.ch    = char_word.name_char;
    push_cmd.store = !is_dot;
    push_cmd.flush = is_dot || char_word.end_of_name;
    push_cmd.last  = char_word.end_of_name;
  end

endmodule

>>> rtl/core/dqle_back.sv
module dqle_back
  import dqle_pkg::*;
#(
  parameter int LABEL_DEPTH = LABEL_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      pop,
  output logic      byte_valid,
  input  logic      byte_stall,
  output out_word_t byte_word
);

  localparam int IW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
  localparam int CW = $clog2(LABEL_DEPTH + 1);

  logic [7:0]    mem [LABEL_DEPTH];
  logic [7:0]    rdata;
  logic [IW-1:0] raddr;
  logic          wr_en;

  back_state_t   state;
  back_state_t   state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          ovf;
  logic          ovf_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] idx_inc;
  logic          cmd_last;
  logic          cmd_last_next;
  logic          can_load;
  logic          load;
  out_word_t     load_word;

  assign can_load = !byte_valid || !byte_stall;
  assign idx_inc  = idx + 1'b1;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    ovf_next      = ovf;
    idx_next      = idx;
    cmd_last_next = cmd_last;
    pop           = 1'b0;
    wr_en         = 1'b0;
    load          = 1'b0;
    load_word     = '0;
    raddr         = idx[IW-1:0];
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_cmd.store) begin
            if (cnt < CW'(LABEL_DEPTH)) begin
              wr_en    = 1'b1;
              cnt_next = cnt + 1'b1;
            end else begin
              ovf_next = 1'b1;
            end
          end
          if (q_cmd.flush) begin
            state_next    = BK_LEN;
            cmd_last_next = q_cmd.last;
          end
        end
      end
      BK_LEN: begin
        raddr = '0;
        if (can_load) begin
          load                     = 1'b1;
          load_word.out_byte       = 8'(cnt);
          load_word.label_overflow = ovf;
          idx_next                 = '0;
          if (cnt == '0) begin
            state_next = cmd_last ? BK_TERM : BK_IDLE;
          end else begin
            state_next = BK_DATA;
          end
        end
      end
      BK_DATA: begin
        if (can_load) begin
          load                     = 1'b1;
          load_word.out_byte       = rdata;
          load_word.label_overflow = ovf;
          raddr = (idx_inc < CW'(LABEL_DEPTH)) ? idx_inc[IW-1:0] : '0;
          if (idx_inc == cnt) begin
            cnt_next   = '0;
            state_next = cmd_last ? BK_TERM : BK_IDLE;
          end else begin
            idx_next = idx_inc;
          end
        end
      end
      BK_TERM: begin
        if (can_load) begin
          load                     = 1'b1;
          load_word.last_byte      = 1'b1;
          load_word.label_overflow = ovf;
          ovf_next                 = 1'b0;
          cnt_next                 = '0;
          state_next               = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      cnt        <= '0;
      ovf        <= 1'b0;
      byte_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
      if (load) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    cmd_last <= cmd_last_next;
    if (load) begin
      byte_word <= load_word;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt[IW-1:0]] <= q_cmd.ch;
    end
    rdata <= mem[raddr];
  end

endmodule
